FILE: hdl/swpd_pkg.sv
// Shared types and constants for the sync word packet deframer.
package swpd_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned BODY_BYTES_DEF     = 153;
  localparam int unsigned CAN_MSG_OFFSET_DEF = 148;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_WORD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP = 1'd1;
  localparam logic [31:0] SYNC_WORD_RST = 32'h6F72_7A21; // "orz!"
  localparam logic [15:0] TIME_STEP_RST = 16'd25;

  // Command word bit patterns (IEEE single precision)
  localparam logic [31:0] CMD_PAD = 32'h4040_0000; // 3.0
  localparam logic [31:0] CMD_IGN = 32'h4000_0000; // 2.0
  localparam logic [31:0] CMD_INJ = 32'h3F80_0000; // 1.0

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PAD  = 2'd1,
    EV_IGN  = 2'd2,
    EV_INJ  = 2'd3
  } event_t;

  // Master-side tdata: body_byte, body_index, phase_event, timestamp, count
  localparam int unsigned M_FIELDS_W = 8 + 8 + 2 + 32 + 32;
  localparam int unsigned M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [31:0] packet_count;
    logic [31:0] timestamp_tenth_ms;
    event_t      phase_event;
    logic        last_byte;
    logic [7:0]  body_index;
    logic [7:0]  body_byte;
  } result_t;

  function automatic event_t decode_event(input logic [31:0] w);
    event_t ev;
    ev = EV_NONE;
    if (w == CMD_PAD) ev = EV_PAD;
    else if (w == CMD_IGN) ev = EV_IGN;
    else if (w == CMD_INJ) ev = EV_INJ;
    return ev;
  endfunction

endpackage

FILE: hdl/sync_word_packet_deframer_core.sv
// Sync word packet deframer: hunts a four-byte sync word, then passes a fixed-length body.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata[7:0] rx_byte
//  m_axis   | out | m_axis_tvalid/tready    | tdata body fields, tlast = last_byte
//  cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
//  One byte is taken every clock while s_axis_tready is high. The header logic
//  and the body update work from the live state registers in the accepting
//  cycle; the result request is registered into the output register, or into
//  the skid register while m_axis stalls. That one-entry skid register feeds
//  the output register and catches the result that arrives during a stall of
//  m_axis; s_axis_tready drops only while the skid register is occupied.
//  rst (synchronous, active high) returns to hunting with all counters zero
//  and the registers at their reset values. cfg is always ready.
module sync_word_packet_deframer_core #(
  parameter int unsigned BODY_BYTES     = swpd_pkg::BODY_BYTES_DEF,
  parameter int unsigned CAN_MSG_OFFSET = swpd_pkg::CAN_MSG_OFFSET_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] rx_byte
  // master side
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] body_byte, [15:8] body_index, [17:16] phase_event,
  // [49:18] timestamp_tenth_ms, [81:50] packet_count, [87:82] zero
  output logic [swpd_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast,   // last_byte
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  // Position limits, all within 8 bits for the legal parameter range
  localparam logic [7:0] LAST_POS = 8'(BODY_BYTES - 1);
  localparam logic [7:0] CMD_POS  = 8'(CAN_MSG_OFFSET);

  // Configuration
  logic [31:0] sync_word;
  logic [15:0] time_step;

  // Deframer state
  logic        in_body;
  logic [1:0]  sync_matched;
  logic [7:0]  body_position;
  logic [31:0] command_word;
  logic [31:0] time_base;
  logic [31:0] completed_packets;

  logic        in_body_next;
  logic [1:0]  sync_matched_next;
  logic [7:0]  body_position_next;
  logic [31:0] command_word_next;
  logic [31:0] time_base_next;
  logic [31:0] completed_packets_next;

  // Output register and skid register
  logic             out_valid;
  swpd_pkg::result_t out_res;
  logic             skid_valid;
  swpd_pkg::result_t skid_res;

  logic             accept;
  logic             res_valid;
  swpd_pkg::result_t res;
  logic             pop;

  logic [7:0]  rx_byte;
  logic [7:0]  expect_byte;
  logic [7:0]  lane_off;
  logic        last;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = ~skid_valid;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Header byte expected next: first one sits in the top byte
  always_comb begin
    unique case (sync_matched)
      2'd0:    expect_byte = sync_word[31:24];
      2'd1:    expect_byte = sync_word[23:16];
      2'd2:    expect_byte = sync_word[15:8];
      default: expect_byte = sync_word[7:0];
    endcase
  end

  assign lane_off = body_position - CMD_POS;
  assign last     = (body_position >= LAST_POS);

  always_comb begin
    in_body_next           = in_body;
    sync_matched_next      = sync_matched;
    body_position_next     = body_position;
    command_word_next      = command_word;
    time_base_next         = time_base;
    completed_packets_next = completed_packets;
    res_valid              = 1'b0;

    if (!in_body) begin
      // Hunting; a mismatching byte is not retried as a first sync byte
      if (rx_byte == expect_byte) begin
        if (sync_matched == 2'd3) begin
          in_body_next       = 1'b1;
          body_position_next = 8'd0;
          sync_matched_next  = 2'd0;
        end else begin
          sync_matched_next = sync_matched + 2'd1;
        end
      end else begin
        sync_matched_next = 2'd0;
      end
    end else begin
      res_valid = 1'b1;
      // Little-endian command word lanes
      if (body_position >= CMD_POS && lane_off < 8'd4) begin
        case (lane_off[1:0])
          2'd0:    command_word_next[7:0]   = rx_byte;
          2'd1:    command_word_next[15:8]  = rx_byte;
          2'd2:    command_word_next[23:16] = rx_byte;
          default: command_word_next[31:24] = rx_byte;
        endcase
      end
      if (last) begin
        completed_packets_next = completed_packets + 32'd1;
        time_base_next         = time_base + {16'd0, time_step};
        in_body_next           = 1'b0;
        sync_matched_next      = 2'd0;
        body_position_next     = 8'd0;
      end else begin
        body_position_next = body_position + 8'd1;
      end
    end

    res.body_byte  = rx_byte;
    res.body_index = body_position;
    res.last_byte  = last;
    if (last) begin
      res.phase_event        = swpd_pkg::decode_event(command_word_next);
      res.timestamp_tenth_ms = time_base_next;
      res.packet_count       = completed_packets_next;
    end else begin
      res.phase_event        = swpd_pkg::EV_NONE;
      res.timestamp_tenth_ms = 32'd0;
      res.packet_count       = 32'd0;
    end
  end

  // State and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word         <= swpd_pkg::SYNC_WORD_RST;
      time_step         <= swpd_pkg::TIME_STEP_RST;
      in_body           <= 1'b0;
      sync_matched      <= 2'd0;
      body_position     <= 8'd0;
      command_word      <= 32'd0;
      time_base         <= 32'd0;
      completed_packets <= 32'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          swpd_pkg::CFG_SYNC_WORD: sync_word <= cfg_data;
          swpd_pkg::CFG_TIME_STEP: time_step <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        in_body           <= in_body_next;
        sync_matched      <= sync_matched_next;
        body_position     <= body_position_next;
        command_word      <= command_word_next;
        time_base         <= time_base_next;
        completed_packets <= completed_packets_next;
      end
    end
  end

  // Output register with skid: pop when the output register is free this cycle
  assign pop = ~out_valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept & res_valid;
      end else begin
        out_valid  <= accept & res_valid;
      end
    end else if (accept & res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end else if (accept & res_valid) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.last_byte;
  assign m_axis_tdata  = {{(swpd_pkg::M_DATA_W - swpd_pkg::M_FIELDS_W){1'b0}},
                          out_res.packet_count,
                          out_res.timestamp_tenth_ms,
                          out_res.phase_event,
                          out_res.body_index,
                          out_res.body_byte};

endmodule

FILE: tb/sv/sync_word_packet_deframer_core_tb.sv
// Self-checking testbench for the sync word packet deframer core.
module sync_word_packet_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int BODY_LEN     = int'(swpd_pkg::BODY_BYTES_DEF);
  localparam int CMD_OFS      = int'(swpd_pkg::CAN_MSG_OFFSET_DEF);
  localparam int SETTLE_CYC   = 4;     // output register plus skid entry, with margin
  localparam int HOLD_CYC     = 500;   // long receiver hold-off to back up the input
  localparam int QUIET_LIMIT  = 5000;  // cycles with no request accepted anywhere
  localparam int PHASE_ITEMS  = 90;    // per setting; one frame usually ends the phase
  localparam int PLAN_ROWS    = 17;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata  = 8'h00;   // [7:0] rx_byte
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // [7:0] body_byte, [15:8] body_index, [17:16] phase_event,
  // [49:18] timestamp_tenth_ms, [81:50] packet_count, [87:82] zero
  logic [swpd_pkg::M_DATA_W-1:0]    m_axis_tdata;
  logic                             m_axis_tlast;            // last_byte
  logic                             cfg_valid     = 1'b0;
  logic                             cfg_ready;
  logic [swpd_pkg::CFG_INDEX_W-1:0] cfg_index     = swpd_pkg::CFG_SYNC_WORD;
  logic [31:0]                      cfg_data      = 32'h0;

  sync_word_packet_deframer_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer predictor: own copy of registers and state
  // ---------------------------------------------------------------------------
  logic [31:0] hdr_word    = swpd_pkg::SYNC_WORD_RST;
  logic [15:0] stamp_step  = swpd_pkg::TIME_STEP_RST;
  bit          in_body     = 1'b0;
  logic [1:0]  hdr_matched = 2'd0;
  logic [7:0]  body_pos    = 8'd0;
  logic [31:0] cmd_word    = 32'h0;
  logic [31:0] time_acc    = 32'h0;
  logic [31:0] pkt_total   = 32'h0;

  swpd_pkg::result_t pending_body [$];   // body results still owed by the block
  int                mismatch_total = 0;
  int                sent_total     = 0;

  // Exact bit match on the float command word
  function automatic swpd_pkg::event_t event_of(input logic [31:0] w);
    case (w)
      swpd_pkg::CMD_PAD: return swpd_pkg::EV_PAD;
      swpd_pkg::CMD_IGN: return swpd_pkg::EV_IGN;
      swpd_pkg::CMD_INJ: return swpd_pkg::EV_INJ;
      default:           return swpd_pkg::EV_NONE;
    endcase
  endfunction

  // Advance the predictor by one received byte; emits is set for a body byte
  task automatic deframe_byte(input logic [7:0] b, output bit emits,
                              output swpd_pkg::result_t r);
    int kk;
    int pos;
    bit fin;
    emits = 1'b0;
    r     = '0;
    if (!in_body) begin
      // hunting: a miss drops back to the first sync byte, no retry of this byte
      kk = hdr_matched;
      if (b == hdr_word[8*(3-kk) +: 8]) begin
        if (kk == 3) begin
          in_body     = 1'b1;
          body_pos    = 8'd0;
          hdr_matched = 2'd0;
        end else begin
          hdr_matched = hdr_matched + 2'd1;
        end
      end else begin
        hdr_matched = 2'd0;
      end
      return;
    end
    pos = body_pos;
    // little-endian lanes of the command word; lanes past the body keep old value
    if (pos >= CMD_OFS && pos - CMD_OFS < 4) cmd_word[8*(pos-CMD_OFS) +: 8] = b;
    fin           = (pos + 1 >= BODY_LEN);
    emits         = 1'b1;
    r.body_byte   = b;
    r.body_index  = pos[7:0];
    r.last_byte   = fin;
    r.phase_event = swpd_pkg::EV_NONE;
    if (fin) begin
      pkt_total            = pkt_total + 32'd1;
      time_acc             = time_acc + {16'h0, stamp_step};
      in_body              = 1'b0;
      hdr_matched          = 2'd0;
      body_pos             = 8'd0;
      r.phase_event        = event_of(cmd_word);
      r.timestamp_tenth_ms = time_acc;
      r.packet_count       = pkt_total;
    end else begin
      body_pos = body_pos + 8'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_total++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted request with the oldest expectation
  // ---------------------------------------------------------------------------
  swpd_pkg::result_t seen_want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_body.size() == 0) begin
        report_mismatch("body result with none pending", 32'(m_axis_tdata[15:0]), 32'h0);
      end else begin
        seen_want = pending_body.pop_front();
        check_field("body_byte",  32'(m_axis_tdata[7:0]),   32'(seen_want.body_byte));
        check_field("body_index", 32'(m_axis_tdata[15:8]),  32'(seen_want.body_index));
        check_field("last_byte",  32'(m_axis_tlast),        32'(seen_want.last_byte));
        check_field("phase_event", 32'(m_axis_tdata[17:16]), 32'(seen_want.phase_event));
        check_field("timestamp",  m_axis_tdata[49:18],      seen_want.timestamp_tenth_ms);
        check_field("packet_count", m_axis_tdata[81:50],    seen_want.packet_count);
        check_field("tdata pad",  32'(m_axis_tdata[swpd_pkg::M_DATA_W-1:82]), 32'h0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotating stall pattern, renewed now and then, plus one long hold
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pat     = 16'hFFFF;
  int          pat_age       = 0;
  int          hold_left     = 0;
  bit          pressure_done = 1'b0;
  bit          want_pressure = 1'b0;   // raised by the stimulus, read here only

  always @(posedge clk) begin
    if (want_pressure && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        // a quarter of the stretches never stall
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pat_age   <= $urandom_range(64, 400);
      end else begin
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
        pat_age   <= pat_age - 1;
      end
      m_axis_tready <= stall_pat[15];
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no request moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // Offer one byte, wait for its request to be taken, then predict it.
  // pin_on replaces the end-of-packet fields with values typed into the plan.
  task automatic send_byte(input logic [7:0] b, input bit pin_on,
                           input swpd_pkg::result_t pin);
    int                gap;
    bit                emits;
    swpd_pkg::result_t r;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent_total++;
    deframe_byte(b, emits, r);
    if (emits) begin
      if (pin_on && r.last_byte) begin
        r.phase_event        = pin.phase_event;
        r.timestamp_tenth_ms = pin.timestamp_tenth_ms;
        r.packet_count       = pin.packet_count;
      end
      pending_body.push_back(r);
    end
  endtask

  // Sync word, then a full body with the command word in its lanes
  task automatic send_frame(input logic [7:0] fill, input bit rand_fill,
                            input logic [31:0] cmd, input bit pin_on,
                            input swpd_pkg::result_t pin);
    logic [7:0] v;
    for (int i = 0; i < 4; i++) send_byte(hdr_word[8*(3-i) +: 8], 1'b0, '0);
    for (int i = 0; i < BODY_LEN; i++) begin
      v = rand_fill ? 8'($urandom) : fill;
      if (i >= CMD_OFS && i - CMD_OFS < 4) v = cmd[8*(i-CMD_OFS) +: 8];
      send_byte(v, pin_on, pin);
    end
  endtask

  // Idle the input and let every owed result drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_body.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // cfg_valid stays high between back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [swpd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == swpd_pkg::CFG_SYNC_WORD) hdr_word = data;
    else stamp_step = data[15:0];
  endtask

  task automatic program_regs(input logic [31:0] sync, input logic [31:0] step_data);
    settle();
    write_reg(swpd_pkg::CFG_SYNC_WORD, sync);
    write_reg(swpd_pkg::CFG_TIME_STEP, step_data);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan, reset settings ("orz!", step 25)
  // ---------------------------------------------------------------------------
  typedef enum logic [0:0] {
    ROW_BYTE  = 1'b0,   // one loose byte while hunting
    ROW_FRAME = 1'b1    // sync word plus full body
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [7:0]        value;       // loose byte, or body fill
    bit                rand_fill;
    logic [31:0]       cmd;
    bit                typed;       // end-of-packet fields below are checked as typed
    swpd_pkg::event_t  ev;
    logic [31:0]       stamp;
    logic [31:0]       count;
  } row_t;

  row_t plan [PLAN_ROWS] = '{
    '{ROW_BYTE,  8'h00, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'hFF, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    // first sync byte twice: the second miss is not taken as a fresh start
    '{ROW_BYTE,  8'h6F, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h6F, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h72, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h7A, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h21, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    // every event code, all-zero and all-one bodies
    '{ROW_FRAME, 8'h00, 1'b0, swpd_pkg::CMD_PAD, 1'b1, swpd_pkg::EV_PAD, 32'd25, 32'd1},
    '{ROW_FRAME, 8'hFF, 1'b0, swpd_pkg::CMD_IGN, 1'b1, swpd_pkg::EV_IGN, 32'd50, 32'd2},
    '{ROW_FRAME, 8'h00, 1'b1, swpd_pkg::CMD_INJ, 1'b1, swpd_pkg::EV_INJ, 32'd75, 32'd3},
    // three sync bytes then a miss on the last one
    '{ROW_BYTE,  8'h6F, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h72, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h7A, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    '{ROW_BYTE,  8'h78, 1'b0, 32'h0, 1'b0, swpd_pkg::EV_NONE, 32'd0, 32'd0},
    // near miss on the pattern, all-ones word, then a code again after them
    '{ROW_FRAME, 8'h00, 1'b1, 32'h4040_0001, 1'b1, swpd_pkg::EV_NONE, 32'd100, 32'd4},
    '{ROW_FRAME, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, swpd_pkg::EV_NONE, 32'd125, 32'd5},
    '{ROW_FRAME, 8'h00, 1'b1, swpd_pkg::CMD_PAD, 1'b1, swpd_pkg::EV_PAD, 32'd150, 32'd6}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    swpd_pkg::result_t pin;
    logic [31:0]       cmd;
    logic [7:0]        fb;
    logic [7:0]        wrong;
    int                pick;
    int                k;
    int                phase_start;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_BYTE) begin
        send_byte(plan[i].value, 1'b0, '0);
      end else begin
        pin                    = '0;
        pin.phase_event        = plan[i].ev;
        pin.timestamp_tenth_ms = plan[i].stamp;
        pin.packet_count       = plan[i].count;
        send_frame(plan[i].value, plan[i].rand_fill, plan[i].cmd, plan[i].typed, pin);
      end
    end

    // Random part over several register settings, extremes first
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_regs(32'h0000_0000, 32'h0000_FFFF);
        1: program_regs(32'hFFFF_FFFF, 32'h0000_0000);
        2: begin
          // repeated sync byte makes the no-retry rule bite
          fb = 8'($urandom);
          program_regs({4{fb}}, $urandom);
        end
        3: program_regs($urandom, $urandom_range(0, 65535));
        default: program_regs(swpd_pkg::SYNC_WORD_RST, {16'h0, swpd_pkg::TIME_STEP_RST});
      endcase
      if (ph == 0) want_pressure <= 1'b1;
      phase_start = sent_total;
      while (sent_total - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // well-formed packet, sometimes after a little line noise
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, '0);
          case ($urandom_range(0, 4))
            0: cmd = swpd_pkg::CMD_PAD;
            1: cmd = swpd_pkg::CMD_IGN;
            2: cmd = swpd_pkg::CMD_INJ;
            3: cmd = $urandom;
            default: cmd = swpd_pkg::CMD_PAD ^ (32'h1 << $urandom_range(0, 31));
          endcase
          send_frame(8'h00, 1'b1, cmd, 1'b0, '0);
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0, '0);
        end else if (pick == 8) begin
          // partial sync broken by a wrong byte
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) send_byte(hdr_word[8*(3-i) +: 8], 1'b0, '0);
          do wrong = 8'($urandom); while (wrong == hdr_word[8*(3-k) +: 8]);
          send_byte(wrong, 1'b0, '0);
        end else begin
          // first sync byte doubled, then the rest of the word
          send_byte(hdr_word[31:24], 1'b0, '0);
          for (int i = 0; i < 4; i++) send_byte(hdr_word[8*(3-i) +: 8], 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/swpd_pkg.sv
hdl/sync_word_packet_deframer_core.sv
tb/sv/sync_word_packet_deframer_core_tb.sv
